### src/bcs_pkg.sv
// Shared types, status codes and register constants for the BCD clock snapshot block.
package bcs_pkg;

   localparam int STATUS_WIDTH   = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int EPOCH_BITS     = 32;
   localparam int PIPE_LATENCY   = 5;

   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam status_type STATUS_VALID      = 3'd0;
   localparam status_type STATUS_HALTED     = 3'd1;
   localparam status_type STATUS_ROLLOVER   = 3'd2;
   localparam status_type STATUS_BAD_BCD    = 3'd3;
   localparam status_type STATUS_OUT_WINDOW = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_HIGH = 2'd1;

   localparam logic [EPOCH_BITS-1:0] WINDOW_LOW_RESET  = 32'd1704067200;
   localparam logic [EPOCH_BITS-1:0] WINDOW_HIGH_RESET = 32'd4102444800;

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [2:0] weekday;
      logic [6:0] year;
   } fields_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      fields_type fields;
   } decode_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      fields_type  fields;
      logic [15:0] days;
      logic [16:0] tod;
   } days_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      fields_type  fields;
      logic [31:0] day_secs;
      logic [16:0] tod;
   } product_type;

   typedef struct packed {
      logic                  valid;
      status_type            status;
      fields_type            fields;
      logic [EPOCH_BITS-1:0] epoch;
   } epoch_type;

endpackage

### src/bcs_check_decode.sv
// First stage: halt, rollover and BCD checks, then BCD to binary decoding.
module bcs_check_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         seconds_register,
   input  logic [7:0]         minutes_register,
   input  logic [7:0]         hours_register,
   input  logic [7:0]         date_register,
   input  logic [7:0]         month_register,
   input  logic [7:0]         weekday_register,
   input  logic [7:0]         year_register,
   input  logic [7:0]         seconds_recheck,
   output bcs_pkg::decode_type out
);
   import bcs_pkg::*;

   function automatic logic [7:0] bcd_value(input logic [7:0] v);
      return {4'd0, v[7:4]} * 8'd10 + {4'd0, v[3:0]};
   endfunction

   function automatic logic bcd_ok(input logic [7:0] v, input logic [7:0] max_bin);
      return (v[3:0] <= 4'd9) && (bcd_value(v) <= max_bin);
   endfunction

   logic [7:0] sec_raw;
   logic [7:0] hour_raw;
   logic       bcd_good;
   decode_type stage_in;
   decode_type stage_ff;

   assign sec_raw  = {1'b0, seconds_register[6:0]};
   assign hour_raw = {2'b00, hours_register[5:0]};

   assign bcd_good = bcd_ok(sec_raw, 8'd59) && bcd_ok(minutes_register, 8'd59) &&
                     bcd_ok(hour_raw, 8'd23) && bcd_ok(date_register, 8'd31) &&
                     bcd_ok(month_register, 8'd12) && bcd_ok(year_register, 8'd99) &&
                     (bcd_value(date_register) != 8'd0) &&
                     (bcd_value(month_register) != 8'd0);

   always_comb begin
      stage_in.valid  = in_valid;
      stage_in.fields = '0;
      if (seconds_register[7]) begin
         stage_in.status = STATUS_HALTED;
      end else if (seconds_recheck[6:0] != seconds_register[6:0]) begin
         stage_in.status = STATUS_ROLLOVER;
      end else if (!bcd_good) begin
         stage_in.status = STATUS_BAD_BCD;
      end else begin
         stage_in.status         = STATUS_VALID;
         stage_in.fields.sec     = 6'(bcd_value(sec_raw));
         stage_in.fields.minute  = 6'(bcd_value(minutes_register));
         stage_in.fields.hour    = 5'(bcd_value(hour_raw));
         stage_in.fields.day     = 5'(bcd_value(date_register));
         stage_in.fields.month   = 4'(bcd_value(month_register));
         stage_in.fields.weekday = weekday_register[2:0];
         stage_in.fields.year    = 7'(bcd_value(year_register));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

### src/bcs_day_count.sv
// Second stage: day count since 1970 and seconds into the day.
module bcs_day_count (
   input  logic                clock,
   input  logic                reset,
   input  bcs_pkg::decode_type in,
   output bcs_pkg::days_type   out
);
   import bcs_pkg::*;

   // Days from 1970-01-01 to 2000-03-01 shifted so that the year term and the
   // day of month can be added directly.
   localparam logic [15:0] DAYS_BASE = 16'd9555;

   // Days from 1 March to the first of each month, March first.
   function automatic logic [8:0] month_offset(input logic [3:0] mp);
      case (mp)
         4'd0:    return 9'd0;
         4'd1:    return 9'd31;
         4'd2:    return 9'd61;
         4'd3:    return 9'd92;
         4'd4:    return 9'd122;
         4'd5:    return 9'd153;
         4'd6:    return 9'd184;
         4'd7:    return 9'd214;
         4'd8:    return 9'd245;
         4'd9:    return 9'd275;
         4'd10:   return 9'd306;
         4'd11:   return 9'd337;
         default: return 9'd0;
      endcase
   endfunction

   logic       early_month;
   logic [3:0] march_month;
   logic [6:0] shifted_year;
   days_type   stage_in;
   days_type   stage_ff;

   always_comb begin
      early_month  = (in.fields.month <= 4'd2);
      march_month  = early_month ? in.fields.month + 4'd9 : in.fields.month - 4'd3;
      // Years counted from 1996, less one for January and February.
      shifted_year = in.fields.year + 7'd4 - {6'd0, early_month};

      stage_in.valid  = in.valid;
      stage_in.status = in.status;
      stage_in.fields = in.fields;
      stage_in.days   = DAYS_BASE + 16'(shifted_year) * 16'd365 +
                        16'(shifted_year[6:2]) + 16'(month_offset(march_month)) +
                        16'(in.fields.day);
      stage_in.tod    = 17'(in.fields.hour) * 17'd3600 +
                        17'(in.fields.minute) * 17'd60 + 17'(in.fields.sec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

### src/bcs_epoch_calc.sv
// Third and fourth stages: day count times seconds per day, then the time of day added.
module bcs_epoch_calc (
   input  logic              clock,
   input  logic              reset,
   input  bcs_pkg::days_type in,
   output bcs_pkg::epoch_type out
);
   import bcs_pkg::*;

   localparam logic [31:0] SECONDS_PER_DAY = 32'd86400;

   product_type product_in;
   product_type product_ff;
   epoch_type   sum_in;
   epoch_type   sum_ff;

   always_comb begin
      product_in.valid    = in.valid;
      product_in.status   = in.status;
      product_in.fields   = in.fields;
      product_in.day_secs = 32'(in.days) * SECONDS_PER_DAY;
      product_in.tod      = in.tod;
   end

   always_comb begin
      sum_in.valid  = product_ff.valid;
      sum_in.status = product_ff.status;
      sum_in.fields = product_ff.fields;
      sum_in.epoch  = product_ff.day_secs + 32'(product_ff.tod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         product_ff <= '0;
         sum_ff     <= '0;
      end else begin
         product_ff <= product_in;
         sum_ff     <= sum_in;
      end
   end

   assign out = sum_ff;

endmodule

### src/bcd_clock_snapshot_to_epoch.sv
// Top level of the BCD clock snapshot to UTC epoch converter.
//
// Usage: present one clock snapshot (seven BCD registers and a second reading
// of the seconds register) on the req_ ports and raise start. The item is
// taken at the rising edge where start is high and busy is low; busy is never
// raised, so a new item may be offered in every cycle.
// Each item gives exactly one result on the rsp_ ports, marked by rsp_valid
// for a single cycle. Throughput is one item per cycle; each item passes
// through five register stages: checks and decoding, day count, the multiply
// by seconds per day, the time-of-day add, and the trust window compare that
// feeds the output register.
// The receiver cannot stall, so the result registers are simply overwritten
// by the next item; nothing is held back.
// The csr_ port writes the trust window: index 0 is the lowest trusted epoch,
// index 1 the epoch at and above which time is untrusted. Other indexes are
// ignored. The window is read in the last stage, so it should be written only
// while no item is in flight.
// Reset is synchronous and active high: it empties the pipeline and restores
// the window to its default values.
module bcd_clock_snapshot_to_epoch (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [7:0]                           req_seconds_register,
   input  logic [7:0]                           req_minutes_register,
   input  logic [7:0]                           req_hours_register,
   input  logic [7:0]                           req_date_register,
   input  logic [7:0]                           req_month_register,
   input  logic [7:0]                           req_weekday_register,
   input  logic [7:0]                           req_year_register,
   input  logic [7:0]                           req_seconds_recheck,
   output logic                                 rsp_valid,
   output bcs_pkg::status_type                  rsp_status,
   output logic [bcs_pkg::EPOCH_BITS-1:0]       rsp_epoch_seconds,
   output logic [5:0]                           rsp_decoded_seconds,
   output logic [5:0]                           rsp_decoded_minutes,
   output logic [4:0]                           rsp_decoded_hours,
   output logic [4:0]                           rsp_decoded_day,
   output logic [3:0]                           rsp_decoded_month,
   output logic [2:0]                           rsp_decoded_weekday,
   output logic [6:0]                           rsp_decoded_year,
   input  logic                                 csr_write,
   input  logic [bcs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bcs_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import bcs_pkg::*;

   logic                  accept;
   decode_type            decoded;
   days_type              day_count;
   epoch_type             epoch;

   logic [EPOCH_BITS-1:0] window_low_ff;
   logic [EPOCH_BITS-1:0] window_high_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_in;
   status_type            rsp_status_ff;
   logic [EPOCH_BITS-1:0] rsp_epoch_in;
   logic [EPOCH_BITS-1:0] rsp_epoch_ff;
   fields_type            rsp_fields_ff;

   // Every stage moves on in every cycle, so the block is always ready.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Trust window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff  <= WINDOW_LOW_RESET;
         window_high_ff <= WINDOW_HIGH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LOW:  window_low_ff  <= csr_data;
            CSR_WINDOW_HIGH: window_high_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bcs_check_decode u_check_decode (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .seconds_register (req_seconds_register),
      .minutes_register (req_minutes_register),
      .hours_register   (req_hours_register),
      .date_register    (req_date_register),
      .month_register   (req_month_register),
      .weekday_register (req_weekday_register),
      .year_register    (req_year_register),
      .seconds_recheck  (req_seconds_recheck),
      .out              (decoded)
   );

   bcs_day_count u_day_count (
      .clock (clock),
      .reset (reset),
      .in    (decoded),
      .out   (day_count)
   );

   bcs_epoch_calc u_epoch_calc (
      .clock (clock),
      .reset (reset),
      .in    (day_count),
      .out   (epoch)
   );

   // Last stage: an item that passed every check is tested against the trust
   // window. An item rejected in the first stage keeps its status and reports a zero epoch; its
   // decoded fields were already cleared in the first stage.
   always_comb begin
      rsp_status_in = epoch.status;
      rsp_epoch_in  = '0;
      if (epoch.status == STATUS_VALID) begin
         rsp_epoch_in = epoch.epoch;
         if (!((epoch.epoch >= window_low_ff) && (epoch.epoch < window_high_ff))) begin
            rsp_status_in = STATUS_OUT_WINDOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= epoch.valid;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_epoch_ff  <= rsp_epoch_in;
      rsp_fields_ff <= epoch.fields;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_epoch_seconds   = rsp_epoch_ff;
   assign rsp_decoded_seconds = rsp_fields_ff.sec;
   assign rsp_decoded_minutes = rsp_fields_ff.minute;
   assign rsp_decoded_hours   = rsp_fields_ff.hour;
   assign rsp_decoded_day     = rsp_fields_ff.day;
   assign rsp_decoded_month   = rsp_fields_ff.month;
   assign rsp_decoded_weekday = rsp_fields_ff.weekday;
   assign rsp_decoded_year    = rsp_fields_ff.year;

endmodule

### src/bcs_checker.sv
// Port-level checks on the snapshot converter, bound to its top level.
module bcs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [7:0]                     req_seconds_register,
   input logic                           rsp_valid,
   input bcs_pkg::status_type            rsp_status,
   input logic [bcs_pkg::EPOCH_BITS-1:0] rsp_epoch_seconds,
   input logic [5:0]                     rsp_decoded_seconds,
   input logic [5:0]                     rsp_decoded_minutes,
   input logic [4:0]                     rsp_decoded_hours,
   input logic [4:0]                     rsp_decoded_day,
   input logic [3:0]                     rsp_decoded_month,
   input logic [2:0]                     rsp_decoded_weekday,
   input logic [6:0]                     rsp_decoded_year
);
   import bcs_pkg::*;

   // Every accepted item yields a result after the pipeline latency.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted item gave no result");

   // No result appears without an item accepted at the matching edge.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without an accepted item");

   // A halted clock is reported as halted, ahead of every other check.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_seconds_register[7]) |->
         ##PIPE_LATENCY (rsp_status == STATUS_HALTED))
      else $error("halted snapshot not reported as halted");

   // A rejected snapshot carries a zero epoch and zero fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_HALTED || rsp_status == STATUS_ROLLOVER ||
                     rsp_status == STATUS_BAD_BCD)) |->
         (rsp_epoch_seconds == '0 && rsp_decoded_seconds == '0 &&
          rsp_decoded_minutes == '0 && rsp_decoded_hours == '0 &&
          rsp_decoded_day == '0 && rsp_decoded_month == '0 &&
          rsp_decoded_weekday == '0 && rsp_decoded_year == '0))
      else $error("rejected snapshot carries non-zero data");

endmodule

bind bcd_clock_snapshot_to_epoch bcs_checker u_bcs_checker (.*);
